// ===== hdl/rksf_pkg.sv =====
package rksf_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_RANGE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SCALE_DISTANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SCALE_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_RANGE            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_SCALE_DISTANCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_SCALE_SPEED      = 3'd5;

  localparam logic [DATA_W-1:0] CLOSE_RANGE_RST = 32'h8000_0000;
  localparam logic [DATA_W-1:0] FAR_RANGE_RST   = 32'h7fff_ffff;

endpackage

// ===== hdl/rksf_if.sv =====
interface rksf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                target_present;
  logic signed [rksf_pkg::DATA_W-1:0]  own_pos_x;
  logic signed [rksf_pkg::DATA_W-1:0]  own_pos_y;
  logic signed [rksf_pkg::DATA_W-1:0]  target_pos_x;
  logic signed [rksf_pkg::DATA_W-1:0]  target_pos_y;
  logic signed [rksf_pkg::DATA_W-1:0]  own_vel_x;
  logic signed [rksf_pkg::DATA_W-1:0]  own_vel_y;
  logic signed [rksf_pkg::DATA_W-1:0]  target_vel_x;
  logic signed [rksf_pkg::DATA_W-1:0]  target_vel_y;

  modport source (output valid, target_present, own_pos_x, own_pos_y, target_pos_x,
                  target_pos_y, own_vel_x, own_vel_y, target_vel_x, target_vel_y,
                  input ready);
  modport sink   (input valid, target_present, own_pos_x, own_pos_y, target_pos_x,
                  target_pos_y, own_vel_x, own_vel_y, target_vel_x, target_vel_y,
                  output ready);
endinterface

interface rksf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rksf_pkg::DATA_W-1:0]  move_x;
  logic signed [rksf_pkg::DATA_W-1:0]  move_y;
  logic                                repel_active;
  logic                                attract_active;

  modport source (output valid, move_x, move_y, repel_active, attract_active,
                  input ready);
  modport sink   (input valid, move_x, move_y, repel_active, attract_active,
                  output ready);
endinterface

// ===== hdl/range_keeping_steering_force.sv =====
// Throughput: one beat per cycle while result is not stalled; the 33-stage square root and the FRACTION_BITS + 1
//   stage divider each resolve one bit per stage, so neither limits the rate.
// Stalls: each stage advances when it is empty or its successor advances, so bubbles
//   collapse; item.ready drops only when every stage holds a beat and result is stalled.
// Reset: rst (synchronous) empties the pipeline and loads the register reset values.
module range_keeping_steering_force #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rksf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rksf_pkg::DATA_W-1:0]         cfg_data,
  rksf_in_if.sink                             item,
  rksf_out_if.source                          result
);

  localparam int F    = FRACTION_BITS;
  localparam int QW   = F + 1;      // unit vector magnitude, at most 2^F
  localparam int NUMW = F + 34;     // divider numerator and shifted divisor
  localparam int PW   = F + 34;     // velocity times unit magnitude
  localparam int HPW  = F + 33;     // 32-bit half times unit magnitude
  localparam int FW   = F + 65;     // recombined move product

  // stage map
  localparam int S_SQ  = 1;
  localparam int S_SUM = 2;
  localparam int S_RT0 = 3;
  localparam int S_DV0 = S_RT0 + 33;
  localparam int S_SPA = S_DV0 + F + 1;
  localparam int S_SPB = S_SPA + 1;
  localparam int S_TMA = S_SPB + 1;
  localparam int S_TMB = S_TMA + 1;
  localparam int S_MG  = S_TMB + 1;
  localparam int S_MVA = S_MG + 1;
  localparam int S_MVB = S_MVA + 1;
  localparam int S_OUT = S_MVB + 1;
  localparam int NST   = S_OUT + 1;

  typedef struct packed {
    logic                   ok;
    logic                   sx;
    logic                   sy;
    logic                   svx;
    logic                   svy;
    logic [32:0]            mdx;
    logic [32:0]            mdy;
    logic [32:0]            mvx;
    logic [32:0]            mvy;
    logic [65:0]            sqx;
    logic [65:0]            sqy;
    logic [67:0]            rem;
    logic [32:0]            root;
    logic [NUMW-1:0]        nrx;
    logic [NUMW-1:0]        nry;
    logic [QW-1:0]          qx;
    logic [QW-1:0]          qy;
    logic [PW-1:0]          pvx;
    logic [PW-1:0]          pvy;
    logic [34:0]            speed;
    logic [34:0]            dcl;
    logic [34:0]            dfa;
    logic [65:0]            pa;
    logic [65:0]            pb;
    logic [65:0]            pc;
    logic [65:0]            pd;
    logic                   sa;
    logic                   sb;
    logic                   sc;
    logic                   sd;
    logic [63:0]            repel;
    logic [63:0]            attract;
    logic                   rep;
    logic                   att;
    logic [63:0]            mr;
    logic [63:0]            ma;
    logic [7:0][HPW-1:0]    pp;
    logic [3:0][63:0]       m;
    logic [31:0]            ox;
    logic [31:0]            oy;
  } st_t;

  // configuration registers
  logic [31:0] close_range;
  logic [31:0] close_scale_distance;
  logic [31:0] close_scale_speed;
  logic [31:0] far_range;
  logic [31:0] far_scale_distance;
  logic [31:0] far_scale_speed;

  st_t            stg [NST];
  st_t            nxt [NST];
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  function automatic logic [33:0] mag35(input logic [34:0] x);
    logic [34:0] t;
    t = x[34] ? (~x + 35'd1) : x;
    return t[33:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] sgn64(input logic [63:0] x, input logic s);
    return s ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [65:0] mulp(input logic [33:0] a, input logic [31:0] b);
    return {32'b0, a} * {34'b0, b};
  endfunction

  function automatic logic [HPW-1:0] mulh(input logic [31:0] a, input logic [QW-1:0] b);
    return {{QW{1'b0}}, a} * {32'b0, b};
  endfunction

  // Write configuration; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      close_range          <= rksf_pkg::CLOSE_RANGE_RST;
      close_scale_distance <= 32'(1) << (F - 4);
      close_scale_speed    <= '0;
      far_range            <= rksf_pkg::FAR_RANGE_RST;
      far_scale_distance   <= 32'(1) << (F - 6);
      far_scale_speed      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rksf_pkg::CFG_CLOSE_RANGE:          close_range          <= cfg_data;
        rksf_pkg::CFG_CLOSE_SCALE_DISTANCE: close_scale_distance <= cfg_data;
        rksf_pkg::CFG_CLOSE_SCALE_SPEED:    close_scale_speed    <= cfg_data;
        rksf_pkg::CFG_FAR_RANGE:            far_range            <= cfg_data;
        rksf_pkg::CFG_FAR_SCALE_DISTANCE:   far_scale_distance   <= cfg_data;
        rksf_pkg::CFG_FAR_SCALE_SPEED:      far_scale_speed      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it advances.
  always_comb begin
    en[NST-1] = !v[NST-1] || result.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign item.ready = en[0];

  // Per-stage datapath. Stage 0 loads the item; each later one copies its predecessor and updates its fields.
  always_comb begin
    st_t               p;
    st_t               n;
    logic [32:0]       dx;
    logic [32:0]       dy;
    logic [32:0]       dvx;
    logic [32:0]       dvy;
    logic [67:0]       trial;
    logic [NUMW-1:0]   numx;
    logic [NUMW-1:0]   numy;
    logic [NUMW-1:0]   dsh;
    logic [34:0]       vx;
    logic [34:0]       vy;
    logic [63:0]       ta;
    logic [63:0]       tb;
    logic [63:0]       tc;
    logic [63:0]       td;
    logic [FW-1:0]     full;
    logic [63:0]       sx64;
    logic [63:0]       sy64;
    int                b;
    int                j;
    for (int i = 0; i < NST; i++) begin
      dx = '0;   dy = '0;   dvx = '0;  dvy = '0;
      trial = '0; numx = '0; numy = '0; dsh = '0;
      vx = '0;   vy = '0;   ta = '0;   tb = '0;   tc = '0;   td = '0;
      full = '0; sx64 = '0; sy64 = '0; b = 0;     j = 0;
      p = stg[(i == 0) ? 0 : i - 1];
      n = p;
      if (i == 0) begin
        n   = '0;
        dx  = {item.target_pos_x[31], item.target_pos_x} - {item.own_pos_x[31], item.own_pos_x};
        dy  = {item.target_pos_y[31], item.target_pos_y} - {item.own_pos_y[31], item.own_pos_y};
        dvx = {item.target_vel_x[31], item.target_vel_x} - {item.own_vel_x[31], item.own_vel_x};
        dvy = {item.target_vel_y[31], item.target_vel_y} - {item.own_vel_y[31], item.own_vel_y};
        n.ok  = item.target_present;
        n.sx  = dx[32];
        n.sy  = dy[32];
        n.svx = dvx[32];
        n.svy = dvy[32];
        n.mdx = dx[32] ? (~dx + 33'd1) : dx;
        n.mdy = dy[32] ? (~dy + 33'd1) : dy;
        n.mvx = dvx[32] ? (~dvx + 33'd1) : dvx;
        n.mvy = dvy[32] ? (~dvy + 33'd1) : dvy;
      end else if (i == S_SQ) begin
        n.sqx = {33'b0, p.mdx} * {33'b0, p.mdx};
        n.sqy = {33'b0, p.mdy} * {33'b0, p.mdy};
      end else if (i == S_SUM) begin
        n.rem  = {2'b0, p.sqx} + {2'b0, p.sqy};
        n.root = '0;
      end else if (i < S_DV0) begin
        // one root bit per stage, most significant first
        b     = 32 - (i - S_RT0);
        trial = (68'(p.root) << (b + 1)) | (68'd1 << (2 * b));
        if (p.rem >= trial) begin
          n.rem     = p.rem - trial;
          n.root[b] = 1'b1;
        end
      end else if (i < S_SPA) begin
        // one quotient bit per stage; a zero root kills the item here
        j = F - (i - S_DV0);
        if (i == S_DV0) begin
          numx = NUMW'(p.mdx) << F;
          numy = NUMW'(p.mdy) << F;
          n.qx = '0;
          n.qy = '0;
          n.ok = p.ok && (p.root != '0);
        end else begin
          numx = p.nrx;
          numy = p.nry;
        end
        dsh   = NUMW'(p.root) << j;
        n.nrx = numx;
        n.nry = numy;
        if (numx >= dsh) begin
          n.nrx   = numx - dsh;
          n.qx[j] = 1'b1;
        end
        if (numy >= dsh) begin
          n.nry   = numy - dsh;
          n.qy[j] = 1'b1;
        end
      end else if (i == S_SPA) begin
        n.pvx = {{(PW-33){1'b0}}, p.mvx} * {{(PW-QW){1'b0}}, p.qx};
        n.pvy = {{(PW-33){1'b0}}, p.mvy} * {{(PW-QW){1'b0}}, p.qy};
        n.svx = p.svx ^ p.sx;
        n.svy = p.svy ^ p.sy;
      end else if (i == S_SPB) begin
        vx      = 35'(p.pvx >> F);
        vy      = 35'(p.pvy >> F);
        n.speed = (p.svx ? (~vx + 35'd1) : vx) + (p.svy ? (~vy + 35'd1) : vy);
        n.dcl   = {2'b0, p.root} - {{3{close_range[31]}}, close_range};
        n.dfa   = {2'b0, p.root} - {{3{far_range[31]}}, far_range};
      end else if (i == S_TMA) begin
        n.pa = mulp(mag35(p.dcl), mag32(close_scale_distance));
        n.pb = mulp(mag35(p.speed), mag32(close_scale_speed));
        n.pc = mulp(mag35(p.dfa), mag32(far_scale_distance));
        n.pd = mulp(mag35(p.speed), mag32(far_scale_speed));
        n.sa = p.dcl[34] ^ close_scale_distance[31];
        n.sb = p.speed[34] ^ close_scale_speed[31];
        n.sc = p.dfa[34] ^ far_scale_distance[31];
        n.sd = p.speed[34] ^ far_scale_speed[31];
      end else if (i == S_TMB) begin
        ta        = 64'(p.pa >> F);
        tb        = 64'(p.pb >> F);
        tc        = 64'(p.pc >> F);
        td        = 64'(p.pd >> F);
        n.repel   = sgn64(ta, p.sa) + sgn64(tb, p.sb);
        n.attract = sgn64(tc, p.sc) + sgn64(td, p.sd);
        n.rep     = p.ok && n.repel[63];
        n.att     = p.ok && !n.attract[63] && (n.attract != '0);
      end else if (i == S_MG) begin
        n.mr = p.rep ? mag64(p.repel) : '0;
        n.ma = p.att ? mag64(p.attract) : '0;
      end else if (i == S_MVA) begin
        n.pp[0] = mulh(p.mr[31:0],  p.qx);
        n.pp[1] = mulh(p.mr[63:32], p.qx);
        n.pp[2] = mulh(p.mr[31:0],  p.qy);
        n.pp[3] = mulh(p.mr[63:32], p.qy);
        n.pp[4] = mulh(p.ma[31:0],  p.qx);
        n.pp[5] = mulh(p.ma[63:32], p.qx);
        n.pp[6] = mulh(p.ma[31:0],  p.qy);
        n.pp[7] = mulh(p.ma[63:32], p.qy);
      end else if (i == S_MVB) begin
        // repel is negative, attract positive: signs follow the offset signs
        for (int k = 0; k < 4; k++) begin
          full   = (FW'(p.pp[2*k+1]) << 32) + FW'(p.pp[2*k]);
          n.m[k] = sgn64(64'(full >> F), ((k == 0) ? ~p.sx : (k == 1) ? ~p.sy :
                                          (k == 2) ? p.sx : p.sy));
        end
      end else begin
        sx64 = p.m[0] + p.m[2];
        sy64 = p.m[1] + p.m[3];
        if (!sx64[63] && (sx64[62:31] != '0)) begin
          n.ox = 32'h7fff_ffff;
        end else if (sx64[63] && (sx64[62:31] != '1)) begin
          n.ox = 32'h8000_0000;
        end else begin
          n.ox = sx64[31:0];
        end
        if (!sy64[63] && (sy64[62:31] != '0)) begin
          n.oy = 32'h7fff_ffff;
        end else if (sy64[63] && (sy64[62:31] != '1)) begin
          n.oy = 32'h8000_0000;
        end else begin
          n.oy = sy64[31:0];
        end
      end
      nxt[i] = n;
    end
  end

  // Valid bits travel with the data; an empty stage takes a bubble.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? item.valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign result.valid          = v[NST-1];
  assign result.move_x         = stg[NST-1].ox;
  assign result.move_y         = stg[NST-1].oy;
  assign result.repel_active   = stg[NST-1].rep;
  assign result.attract_active = stg[NST-1].att;

  // input is refused only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (&v) && !result.ready)
    else $error("input refused with a free stage");

  // no term applied means no move
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.repel_active && !result.attract_active
      |-> result.move_x == 0 && result.move_y == 0)
    else $error("move without an applied term");

  a_rst_empty: assert property (@(posedge clk) rst |=> !result.valid && !v[0])
    else $error("pipeline not emptied by reset");

endmodule
